// ===== src/riff_wav_header_parser_assert.svh =====
// Assertion macros for the RIFF/WAVE header parser.
`ifndef RIFF_WAV_HEADER_PARSER_ASSERT_SVH
`define RIFF_WAV_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RIFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("riff parser check failed");

// Next-cycle implication, disabled during reset.
`define RIFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("riff parser check failed");

`endif

// ===== src/riff_pkg.sv =====
// Shared types and constants for the RIFF/WAVE header parser.
package riff_pkg;

  typedef enum logic [2:0] {
    PH_GLOBAL = 3'd0,
    PH_HEADER = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_END    = 3'd4,
    PH_FAULT  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIGNATURE = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_FMT_SHORT = 3'd3,
    ST_SIZE      = 3'd4
  } status_t;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  typedef struct packed {
    status_t     status;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate_hz;
    logic [31:0] byte_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } result_t;

endpackage

// ===== src/riff_parse.sv =====
// Parser state registers and per-byte next-state logic.
module riff_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       data_byte,
  input  logic             end_of_file,
  output riff_pkg::result_t result
);

  riff_pkg::phase_t  phase, phase_next;
  riff_pkg::status_t error_code, error_code_next;
  logic [3:0]  field_byte_index, field_byte_index_next;
  logic [31:0] chunk_id_shift, chunk_id_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] riff_remaining, riff_remaining_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] sample_rate_hz, sample_rate_hz_next;
  logic [31:0] byte_rate, byte_rate_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic [31:0] data_size_seen, data_size_seen_next;

  logic [31:0] id_shifted;
  logic [31:0] len_shifted;
  logic [32:0] need;

  assign id_shifted  = {data_byte, chunk_id_shift[31:8]};
  assign len_shifted = {data_byte, chunk_length[31:8]};
  assign need        = {1'b0, len_shifted} + 33'd8;

  always_comb begin
    phase_next            = phase;
    error_code_next       = error_code;
    field_byte_index_next = field_byte_index;
    chunk_id_shift_next   = chunk_id_shift;
    chunk_length_next     = chunk_length;
    riff_remaining_next   = riff_remaining;
    chunk_remaining_next  = chunk_remaining;
    format_code_next      = format_code;
    channel_count_next    = channel_count;
    sample_rate_hz_next   = sample_rate_hz;
    byte_rate_next        = byte_rate;
    sample_bits_next      = sample_bits;
    data_size_seen_next   = data_size_seen;

    unique case (phase)
      riff_pkg::PH_GLOBAL: begin
        if (field_byte_index < 4'd4 || field_byte_index >= 4'd8) begin
          chunk_id_shift_next = id_shifted;
        end else begin
          chunk_length_next = len_shifted;
        end
        field_byte_index_next = 4'(field_byte_index + 4'd1);
        if (field_byte_index == 4'd3 && id_shifted != riff_pkg::ID_RIFF) begin
          error_code_next = riff_pkg::ST_SIGNATURE;
          phase_next      = riff_pkg::PH_FAULT;
        end else if (field_byte_index == 4'd11) begin
          if (id_shifted != riff_pkg::ID_WAVE) begin
            error_code_next = riff_pkg::ST_SIGNATURE;
            phase_next      = riff_pkg::PH_FAULT;
          end else if (chunk_length < 32'd4) begin
            error_code_next = riff_pkg::ST_SIZE;
            phase_next      = riff_pkg::PH_FAULT;
          end else begin
            riff_remaining_next   = chunk_length - 32'd4;
            chunk_remaining_next  = '0;
            field_byte_index_next = '0;
            phase_next = (chunk_length == 32'd4) ? riff_pkg::PH_END : riff_pkg::PH_HEADER;
          end
        end
      end
      riff_pkg::PH_HEADER: begin
        if (field_byte_index < 4'd4) begin
          chunk_id_shift_next = id_shifted;
        end else begin
          chunk_length_next = len_shifted;
        end
        field_byte_index_next = 4'(field_byte_index + 4'd1);
        if (field_byte_index == 4'd7) begin
          if (chunk_id_shift == riff_pkg::ID_FMT && len_shifted < 32'd16) begin
            error_code_next = riff_pkg::ST_FMT_SHORT;
            phase_next      = riff_pkg::PH_FAULT;
          end else if (need > {1'b0, riff_remaining}) begin
            error_code_next = riff_pkg::ST_SIZE;
            phase_next      = riff_pkg::PH_FAULT;
          end else begin
            riff_remaining_next   = riff_remaining - need[31:0];
            field_byte_index_next = '0;
            if (chunk_id_shift == riff_pkg::ID_FMT) begin
              chunk_remaining_next = len_shifted - 32'd16;
              phase_next           = riff_pkg::PH_FMT;
            end else begin
              if (chunk_id_shift == riff_pkg::ID_DATA) begin
                data_size_seen_next = len_shifted;
              end
              chunk_remaining_next = len_shifted;
              if (len_shifted != '0) begin
                phase_next = riff_pkg::PH_SKIP;
              end else if (riff_remaining_next == '0) begin
                phase_next = riff_pkg::PH_END;
              end else begin
                phase_next = riff_pkg::PH_HEADER;
              end
            end
          end
        end
      end
      riff_pkg::PH_FMT: begin
        unique case (field_byte_index)
          4'd0:  format_code_next[7:0]     = data_byte;
          4'd1:  format_code_next[15:8]    = data_byte;
          4'd2:  channel_count_next[7:0]   = data_byte;
          4'd3:  channel_count_next[15:8]  = data_byte;
          4'd4:  sample_rate_hz_next[7:0]  = data_byte;
          4'd5:  sample_rate_hz_next[15:8] = data_byte;
          4'd6:  sample_rate_hz_next[23:16] = data_byte;
          4'd7:  sample_rate_hz_next[31:24] = data_byte;
          4'd8:  byte_rate_next[7:0]       = data_byte;
          4'd9:  byte_rate_next[15:8]      = data_byte;
          4'd10: byte_rate_next[23:16]     = data_byte;
          4'd11: byte_rate_next[31:24]     = data_byte;
          4'd14: sample_bits_next[7:0]     = data_byte;
          4'd15: sample_bits_next[15:8]    = data_byte;
          default: ;  // block align is not reported
        endcase
        field_byte_index_next = 4'(field_byte_index + 4'd1);
        if (field_byte_index == 4'd15) begin
          if (chunk_remaining != '0) begin
            phase_next = riff_pkg::PH_SKIP;
          end else if (riff_remaining == '0) begin
            phase_next = riff_pkg::PH_END;
          end else begin
            phase_next = riff_pkg::PH_HEADER;
          end
        end
      end
      riff_pkg::PH_SKIP: begin
        chunk_remaining_next = chunk_remaining - 32'd1;
        if (chunk_remaining == 32'd1) begin
          field_byte_index_next = '0;
          phase_next = (riff_remaining == '0) ? riff_pkg::PH_END : riff_pkg::PH_HEADER;
        end
      end
      riff_pkg::PH_END: begin
        error_code_next = riff_pkg::ST_SIZE;
        phase_next      = riff_pkg::PH_FAULT;
      end
      default: ;
    endcase
  end

  // Global-header size check uses the length after the last byte shifts in.
  // Byte 11 lands in the id register, so chunk_length already holds the size.

  always_comb begin
    if (error_code_next != riff_pkg::ST_OK) begin
      result.status = error_code_next;
    end else if (phase_next == riff_pkg::PH_END) begin
      result.status = riff_pkg::ST_OK;
    end else begin
      result.status = riff_pkg::ST_TRUNCATED;
    end
    result.format_code    = format_code_next;
    result.channel_count  = channel_count_next;
    result.sample_rate_hz = sample_rate_hz_next;
    result.byte_rate      = byte_rate_next;
    result.sample_bits    = sample_bits_next;
    result.data_length    = data_size_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (go && end_of_file)) begin
      phase            <= riff_pkg::PH_GLOBAL;
      error_code       <= riff_pkg::ST_OK;
      field_byte_index <= '0;
      chunk_id_shift   <= '0;
      chunk_length     <= '0;
      riff_remaining   <= '0;
      chunk_remaining  <= '0;
      format_code      <= '0;
      channel_count    <= '0;
      sample_rate_hz   <= '0;
      byte_rate        <= '0;
      sample_bits      <= '0;
      data_size_seen   <= '0;
    end else if (go) begin
      phase            <= phase_next;
      error_code       <= error_code_next;
      field_byte_index <= field_byte_index_next;
      chunk_id_shift   <= chunk_id_shift_next;
      chunk_length     <= chunk_length_next;
      riff_remaining   <= riff_remaining_next;
      chunk_remaining  <= chunk_remaining_next;
      format_code      <= format_code_next;
      channel_count    <= channel_count_next;
      sample_rate_hz   <= sample_rate_hz_next;
      byte_rate        <= byte_rate_next;
      sample_bits      <= sample_bits_next;
      data_size_seen   <= data_size_seen_next;
    end
  end

endmodule

// ===== src/riff_out.sv =====
// Result register for the header parser output channel.
module riff_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  riff_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output riff_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ===== src/riff_wav_header_parser.sv =====
// Top level of the byte-serial RIFF/WAVE header parser.
//
//   channel | signals                                   | moves
//   in      | in_valid, in_stall, data_byte, end_of_file | one file byte
//   out     | out_valid, out_stall, status .. data_length | one file report
//
// One byte per cycle unless stalled; a report loads as its last byte parses.
// Throughput is set by the single parse step between the input register and
// the result register. Synchronous reset clears the parse state; the parser
// also returns to its reset state after every last byte.
// Only a last-byte transaction can wait in the input register, while the
// result register is still held by out_stall.
module riff_wav_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] format_code,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate_hz,
  output logic [31:0] byte_rate,
  output logic [15:0] sample_bits,
  output logic [31:0] data_length
);

  `include "riff_wav_header_parser_assert.svh"

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eof;
  logic       s1_go;

  riff_pkg::result_t parse_result;
  riff_pkg::result_t out_result;

  assign s1_go    = s1_valid && (!s1_eof || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_eof  <= end_of_file;
    end
  end

  riff_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .data_byte   (s1_byte),
    .end_of_file (s1_eof),
    .result      (parse_result)
  );

  riff_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_go && s1_eof),
    .result_in (parse_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (out_result)
  );

  assign status         = out_result.status;
  assign format_code    = out_result.format_code;
  assign channel_count  = out_result.channel_count;
  assign sample_rate_hz = out_result.sample_rate_hz;
  assign byte_rate      = out_result.byte_rate;
  assign sample_bits    = out_result.sample_bits;
  assign data_length    = out_result.data_length;

  `RIFF_ASSERT_NOW(a_stall_only_on_eof, in_stall, s1_valid && s1_eof && out_valid && out_stall)
  `RIFF_ASSERT_NEXT(a_eof_gives_report, s1_go && s1_eof, out_valid)
  `RIFF_ASSERT_NOW(a_status_legal, out_valid, status <= riff_pkg::ST_SIZE)

endmodule

// ===== tb/sv/tb_riff_wav_header_parser.sv =====
// Testbench for riff_wav_header_parser: random and directed WAV files checked against a predictor.
module tb_riff_wav_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import riff_pkg::*;

  class wav_report_board;
    phase_t      phase;
    status_t     err;
    logic [3:0]  idx;
    logic [31:0] id_shift;
    logic [31:0] chunk_len;
    logic [31:0] riff_left;
    logic [31:0] chunk_left;
    logic [63:0] fmt_lo;
    logic [63:0] fmt_hi;
    logic [31:0] data_len;
    result_t     expected_reports[$];
    int          errors;

    function void clear_state();
      phase      = PH_GLOBAL;
      err        = ST_OK;
      idx        = '0;
      id_shift   = '0;
      chunk_len  = '0;
      riff_left  = '0;
      chunk_left = '0;
      fmt_lo     = '0;
      fmt_hi     = '0;
      data_len   = '0;
    endfunction

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void fault(status_t code);
      err   = code;
      phase = PH_FAULT;
    endfunction

    function void next_boundary();
      idx = '0;
      if (chunk_left != 0) begin
        phase = PH_SKIP;
      end else begin
        phase = (riff_left == 0) ? PH_END : PH_HEADER;
      end
    endfunction

    function void parse(logic [7:0] b);
      logic [3:0]  i;
      logic [32:0] need;
      i = idx;
      case (phase)
        PH_GLOBAL: begin
          if (i < 4 || i >= 8) id_shift = {b, id_shift[31:8]};
          else chunk_len = {b, chunk_len[31:8]};
          idx = i + 4'd1;
          if (i == 4'd3 && id_shift != ID_RIFF) begin
            fault(ST_SIGNATURE);
          end else if (i == 4'd11) begin
            if (id_shift != ID_WAVE) begin
              fault(ST_SIGNATURE);
            end else if (chunk_len < 4) begin
              fault(ST_SIZE);
            end else begin
              riff_left  = chunk_len - 32'd4;
              chunk_left = '0;
              next_boundary();
            end
          end
        end
        PH_HEADER: begin
          if (i < 4) id_shift = {b, id_shift[31:8]};
          else chunk_len = {b, chunk_len[31:8]};
          idx = i + 4'd1;
          if (i == 4'd7) begin
            need = {1'b0, chunk_len} + 33'd8;
            if (id_shift == ID_FMT && chunk_len < 16) begin
              fault(ST_FMT_SHORT);
            end else if (need > {1'b0, riff_left}) begin
              fault(ST_SIZE);
            end else begin
              riff_left = riff_left - need[31:0];
              idx = '0;
              if (id_shift == ID_FMT) begin
                chunk_left = chunk_len - 32'd16;
                phase      = PH_FMT;
              end else begin
                if (id_shift == ID_DATA) data_len = chunk_len;
                chunk_left = chunk_len;
                next_boundary();
              end
            end
          end
        end
        PH_FMT: begin
          if (i < 8) fmt_lo[8*i +: 8] = b;
          else fmt_hi[8*(i-8) +: 8] = b;
          idx = i + 4'd1;
          if (i == 4'd15) next_boundary();
        end
        PH_SKIP: begin
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) next_boundary();
        end
        PH_END: fault(ST_SIZE);
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic eof);
      result_t r;
      parse(b);
      if (eof) begin
        if (err != ST_OK) r.status = err;
        else r.status = (phase == PH_END) ? ST_OK : ST_TRUNCATED;
        r.format_code    = fmt_lo[15:0];
        r.channel_count  = fmt_lo[31:16];
        r.sample_rate_hz = fmt_lo[63:32];
        r.byte_rate      = fmt_hi[31:0];
        r.sample_bits    = fmt_hi[63:48];
        r.data_length    = data_len;
        expected_reports.push_back(r);
        clear_state();
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        report("unexpected report", got.data_length, 32'h0);
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.format_code !== want.format_code)
        report("format_code", got.format_code, want.format_code);
      if (got.channel_count !== want.channel_count)
        report("channel_count", got.channel_count, want.channel_count);
      if (got.sample_rate_hz !== want.sample_rate_hz)
        report("sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
      if (got.byte_rate !== want.byte_rate)
        report("byte_rate", got.byte_rate, want.byte_rate);
      if (got.sample_bits !== want.sample_bits)
        report("sample_bits", got.sample_bits, want.sample_bits);
      if (got.data_length !== want.data_length)
        report("data_length", got.data_length, want.data_length);
    endtask

    task check_leftover();
      if (expected_reports.size() != 0)
        report("reports missing", expected_reports.size(), 32'h0);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] sample_rate_hz;
  logic [31:0] byte_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_length;

  wav_report_board board = new();
  logic [7:0]      body_q[$];
  logic [7:0]      file_q[$];
  int              bytes_sent;
  bit              no_idle;
  int              stall_left;

  riff_wav_header_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_file    (end_of_file),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .format_code    (format_code),
    .channel_count  (channel_count),
    .sample_rate_hz (sample_rate_hz),
    .byte_rate      (byte_rate),
    .sample_bits    (sample_bits),
    .data_length    (data_length)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // receiver back-pressure: short bursts, occasional long stalls and clean stretches
  initial out_stall = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(0, 6);
        end
        5, 6, 7: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(0, 2);
        end
        8: begin
          out_stall  <= 1'b1;
          stall_left = $urandom_range(10, 40);
        end
        default: begin
          out_stall  <= 1'b0;
          stall_left = $urandom_range(20, 60);
        end
      endcase
    end
  end

  // outputs are stable mid-cycle; a transaction seen here completes at the next edge
  always @(negedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status         = status_t'(status);
      got.format_code    = format_code;
      got.channel_count  = channel_count;
      got.sample_rate_hz = sample_rate_hz;
      got.byte_rate      = byte_rate;
      got.sample_bits    = sample_bits;
      got.data_length    = data_length;
      board.check_report(got);
    end
  end

  function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v);
    for (int k = 0; k < 4; k++) q.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_chunk(logic [31:0] id, logic [31:0] len, int nbody, int fill);
    push_le(body_q, id);
    push_le(body_q, len);
    repeat (nbody) body_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic void make_file(logic [31:0] riff_size);
    file_q.delete();
    push_le(file_q, ID_RIFF);
    push_le(file_q, riff_size);
    push_le(file_q, ID_WAVE);
    foreach (body_q[k]) file_q.push_back(body_q[k]);
  endfunction

  function automatic int idle_cycles();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    bit stalled;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= eof;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    board.take_byte(b, eof);
  endtask

  task automatic send_file();
    no_idle = ($urandom_range(0, 3) == 0);
    foreach (file_q[k]) send_byte(file_q[k], k == file_q.size() - 1);
    bytes_sent += file_q.size();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic run_directed();
    // smallest legal file: header only, budget exactly used
    body_q.delete();
    make_file(32'd4);
    send_file();
    // one lone byte
    file_q = '{8'h52};
    send_file();
    // bad RIFF tag, later bytes ignored
    make_file(32'd4);
    file_q[3] = 8'h58;
    file_q.push_back(8'hFF);
    send_file();
    // RIFF size below the WAVE tag
    make_file(32'd3);
    send_file();
    // bad WAVE tag
    make_file(32'd4);
    file_q[11] = 8'h46;
    send_file();
    // fmt chunk too short
    add_chunk(ID_FMT, 32'd15, 15, -1);
    make_file(32'd4 + body_q.size());
    send_file();
    // all-ones fmt fields, empty data chunk
    body_q.delete();
    add_chunk(ID_FMT, 32'd16, 16, 8'hFF);
    add_chunk(ID_DATA, 32'd0, 0, 0);
    make_file(32'd4 + body_q.size());
    send_file();
    // a later fmt overrides, with extra bytes skipped
    body_q.delete();
    add_chunk(ID_FMT, 32'd16, 16, 8'hFF);
    add_chunk(ID_FMT, 32'd18, 18, 8'h00);
    add_chunk(ID_DATA, 32'd3, 3, -1);
    make_file(32'd4 + body_q.size());
    send_file();
    // trailing byte past the budget
    body_q.delete();
    make_file(32'd4);
    file_q.push_back(8'h00);
    send_file();
    // chunk length overruns the budget
    add_chunk(ID_DATA, 32'hFFFF_FFFF, 0, 0);
    make_file(32'd4 + body_q.size());
    send_file();
    // huge budget, file ends at a chunk boundary
    body_q.delete();
    make_file(32'hFFFF_FFFF);
    send_file();
    // data chunk length overruns the budget, file cut inside its body
    body_q.delete();
    add_chunk(ID_DATA, 32'd8, 3, -1);
    make_file(32'd16);
    send_file();
  endtask

  task automatic build_random_file();
    int          kind;
    int          len;
    int          mode;
    int          pos;
    logic [31:0] riff_size;
    body_q.delete();
    repeat ($urandom_range(0, 4)) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : 16;
        add_chunk(ID_FMT, len, len, -1);
      end else if (kind < 7) begin
        len = $urandom_range(0, 10);
        add_chunk(ID_DATA, len, len, -1);
      end else begin
        len = $urandom_range(0, 8);
        add_chunk($urandom, len, len, -1);
      end
    end
    mode = $urandom_range(0, 19);
    if (mode == 16) begin
      len = $urandom_range(0, 15);
      add_chunk(ID_FMT, len, len, -1);
    end
    if (mode == 17)
      add_chunk($urandom_range(0, 1) ? ID_DATA : $urandom,
                $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom | 32'h8000_0000,
                $urandom_range(0, 3), -1);
    riff_size = 32'd4 + body_q.size();
    if (mode == 14)
      riff_size = ($urandom_range(0, 2) == 0) ? $urandom : riff_size + $urandom_range(0, 12) - 6;
    if (mode == 19) riff_size = $urandom;
    make_file(riff_size);
    if (mode == 12 || mode == 19) begin
      pos = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > pos) void'(file_q.pop_back());
    end
    if (mode == 13) repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
    if (mode == 15) begin
      pos = $urandom_range(0, 7);
      if (pos >= 4) pos += 4;
      file_q[pos] = file_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (mode == 18) begin
      file_q.delete();
      repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    int files;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    end_of_file = 1'b0;
    bytes_sent  = 0;
    files       = 0;
    no_idle     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain();
    while (bytes_sent < 1550) begin
      build_random_file();
      send_file();
      files++;
      if (files % 15 == 7) drain();
    end
    drain();
    repeat (10) @(posedge clk);
    board.check_leftover();
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== riff_wav_header_parser.f =====
+incdir+src
src/riff_pkg.sv
src/riff_parse.sv
src/riff_out.sv
src/riff_wav_header_parser.sv
tb/sv/tb_riff_wav_header_parser.sv
